// ===== src/hsfp_pkg.sv =====
// Shared constants, types and character helpers for the hex sensor frame parser.
`default_nettype none
package hsfp_pkg;

  // Field widths
  localparam int CH_W     = 8;
  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int STATUS_W = 2;

  // Default line length in 16-bit words
  localparam int WORDS_PER_LINE_DEF = 10;

  // Characters of interest
  localparam logic [CH_W-1:0] CH_COLON = 8'h3a;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0a;
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADHEX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

  // One character held between the input stage and the parser
  typedef struct packed {
    logic            vld;
    logic [CH_W-1:0] ch;
  } char_item_t;

  // Decode a lowercase hex digit: bit 4 flags a valid digit, bits 3:0 its value
  function automatic logic [4:0] hex_nibble(input logic [CH_W-1:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/hsfp_in_reg.sv =====
// Input register stage: holds one character until the parser takes it.
`default_nettype none
module hsfp_in_reg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [hsfp_pkg::CH_W-1:0]    in_ch,
  input  wire logic                         take,
  output hsfp_pkg::char_item_t              item
);

  logic                      vld;
  logic [hsfp_pkg::CH_W-1:0] ch;

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch <= in_ch;
    end
  end

  assign item.vld = vld;
  assign item.ch  = ch;

endmodule
`default_nettype wire

// ===== src/hsfp_core.sv =====
// Line parser: phase, digit counter, word assembly and the result register.
`default_nettype none
module hsfp_core #(
  parameter int WORDS_PER_LINE = hsfp_pkg::WORDS_PER_LINE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire hsfp_pkg::char_item_t             item,
  output logic                                  take,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output logic [hsfp_pkg::CHAN_W-1:0]           res_channel,
  output logic signed [hsfp_pkg::SAMPLE_W-1:0]  res_sample,
  output logic [hsfp_pkg::STATUS_W-1:0]         res_status,
  output logic                                  res_last
);

  localparam int CNT_W  = $clog2(4 * WORDS_PER_LINE);
  localparam int WORD_W = CNT_W - 2;
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS_PER_LINE - 1);

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_SKIP,
    PH_COLLECT,
    PH_DONE
  } phase_t;

  phase_t                         phase, phase_next;
  logic [CNT_W-1:0]               digit_count, digit_count_next;
  logic [hsfp_pkg::SAMPLE_W-1:0]  word_accum, word_accum_next;
  logic                           digit_error, digit_error_next;

  logic                           emit;
  logic [hsfp_pkg::CHAN_W-1:0]    o_channel;
  logic [hsfp_pkg::SAMPLE_W-1:0]  o_sample;
  logic [hsfp_pkg::STATUS_W-1:0]  o_status;
  logic                           o_last;

  logic                           term;
  logic [1:0]                     pos;
  logic [WORD_W-1:0]              word;
  logic [4:0]                     nib;
  logic [hsfp_pkg::SAMPLE_W-1:0]  nib_word;
  logic [hsfp_pkg::SAMPLE_W-1:0]  accum_base;
  logic                           err_base;
  logic                           word_last;

  // Take a character when the result register can hold what it yields
  assign take = item.vld && (!res_valid || res_ready);

  assign term      = (item.ch == hsfp_pkg::CH_NL) || (item.ch == hsfp_pkg::CH_NUL);
  assign pos       = digit_count[1:0];
  assign word      = digit_count[CNT_W-1:2];
  assign nib       = hsfp_pkg::hex_nibble(item.ch);
  assign word_last = (word == LAST_WORD);

  // Digits arrive low byte first, high nibble first within each byte
  always_comb begin
    case (pos)
      2'd0:    nib_word = {8'h00, nib[3:0], 4'h0};
      2'd1:    nib_word = {12'h000, nib[3:0]};
      2'd2:    nib_word = {nib[3:0], 12'h000};
      default: nib_word = {4'h0, nib[3:0], 8'h00};
    endcase
    accum_base = (pos == 2'd0) ? '0 : word_accum;
    err_base   = (pos == 2'd0) ? 1'b0 : digit_error;
  end

  // Next state and result for the held character
  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    word_accum_next  = word_accum;
    digit_error_next = digit_error;
    emit             = 1'b0;
    o_channel        = '0;
    o_sample         = '0;
    o_status         = hsfp_pkg::ST_SHORT;
    o_last           = 1'b1;
    case (phase)
      PH_SEEK: begin
        if (item.ch == hsfp_pkg::CH_COLON) begin
          phase_next       = PH_SKIP;
          digit_count_next = '0;
          digit_error_next = 1'b0;
        end
      end
      PH_SKIP: begin
        if (term) begin
          phase_next       = PH_SEEK;
          digit_count_next = '0;
          digit_error_next = 1'b0;
          emit             = 1'b1;
        end else begin
          phase_next = PH_COLLECT;
        end
      end
      PH_COLLECT: begin
        if (term) begin
          // line ended before all words arrived
          phase_next       = PH_SEEK;
          digit_count_next = '0;
          digit_error_next = 1'b0;
          emit             = 1'b1;
        end else if (item.ch != hsfp_pkg::CH_SPACE) begin
          word_accum_next  = nib[4] ? (accum_base | nib_word) : accum_base;
          digit_error_next = err_base || !nib[4];
          digit_count_next = digit_count + 1'b1;
          if (pos == 2'd3) begin
            if (word_last) begin
              phase_next = PH_DONE;
            end
            // timestamp word is dropped
            emit      = (word != '0);
            o_channel = hsfp_pkg::CHAN_W'(word) - 1'b1;
            o_sample  = digit_error_next ? '0 : word_accum_next;
            o_status  = digit_error_next ? hsfp_pkg::ST_BADHEX : hsfp_pkg::ST_OK;
            o_last    = word_last;
          end
        end
      end
      default: begin
        if (term) begin
          phase_next       = PH_SEEK;
          digit_count_next = '0;
          digit_error_next = 1'b0;
        end
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SEEK;
      digit_count <= '0;
      word_accum  <= '0;
      digit_error <= 1'b0;
      res_valid   <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      word_accum  <= word_accum_next;
      digit_error <= digit_error_next;
      res_valid   <= emit;
      if (emit) begin
        res_channel <= o_channel;
        res_sample  <= o_sample;
        res_status  <= o_status;
        res_last    <= o_last;
      end
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/hex_sensor_frame_parser.sv =====
// Top level of the hex sensor frame parser: input stage, parser and ports.
//
//  Group  Dir  Signals                      Contents
//  s_*    in   tvalid tready tdata[7:0]     one text character of the line
//  m_*    out  tvalid tready tdata tuser    one decoded sensor word or
//              tlast                        a short-line marker
//
// One character is taken per cycle unless a stalled result holds the parser; a
// character is first held in the input register, then parsed into the result
// register when the parser takes it.
// Synchronous reset clears the input stage, the result valid and the parser
// to the seek-colon phase. A stalled result holds the result register; the
// input register still takes one more character behind it.
`default_nettype none
module hex_sensor_frame_parser #(
  parameter int WORDS_PER_LINE = hsfp_pkg::WORDS_PER_LINE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [3:0] channel, [19:4] sample, [23:20] zero
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic             m_tlast
);

  hsfp_pkg::char_item_t                   item;
  logic                                   take;
  logic [hsfp_pkg::CHAN_W-1:0]            channel;
  logic signed [hsfp_pkg::SAMPLE_W-1:0]   sample;

  hsfp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_ch    (s_tdata),
    .take     (take),
    .item     (item)
  );

  hsfp_core #(
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .take        (take),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res_channel (channel),
    .res_sample  (sample),
    .res_status  (m_tuser),
    .res_last    (m_tlast)
  );

  // Pack result fields, low field first
  assign m_tdata = {4'h0, sample, channel};

`ifndef ASSERT_OFF
  // A short-line marker is always the last item of its line and carries zero
  a_short_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == hsfp_pkg::ST_SHORT) |-> (m_tlast && sample == '0 && channel == '0))
    else $error("short-line result malformed");

  // A word with a bad digit reads as zero
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == hsfp_pkg::ST_BADHEX) |-> (sample == '0))
    else $error("bad-digit result carries a nonzero sample");

  // Word results stay within the sensor channels, last only on the final one
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != hsfp_pkg::ST_SHORT) |->
      (channel <= hsfp_pkg::CHAN_W'(WORDS_PER_LINE - 2) &&
       m_tlast == (channel == hsfp_pkg::CHAN_W'(WORDS_PER_LINE - 2))))
    else $error("word result channel or last flag out of place");

  // The parser only takes a character the input stage holds
  a_take_held: assert property (@(posedge clk) disable iff (rst)
    take |-> item.vld)
    else $error("parser took from an empty input stage");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the hex sensor frame parser: directed lines, then random lines.
`timescale 1ns / 100ps
module tb;

  // One decoded result as it leaves the block
  typedef struct packed {
    logic [hsfp_pkg::CHAN_W-1:0]          channel;
    logic signed [hsfp_pkg::SAMPLE_W-1:0] sample;
    logic [hsfp_pkg::STATUS_W-1:0]        status;
    logic                                 last;
  } sensor_word_t;

  // One character sent, with a typed-in result where it is obvious
  typedef struct packed {
    logic [hsfp_pkg::CH_W-1:0] ch;
    logic                      fixed;
    sensor_word_t              word;
  } char_row_t;

  typedef enum logic [1:0] {SEEK_COLON, SKIP_ONE, COLLECT, LINE_DONE} parse_phase_t;

  localparam int NUM_WORDS    = hsfp_pkg::WORDS_PER_LINE_DEF;
  localparam int LINE_DIGITS  = 4 * NUM_WORDS;
  // least number of characters sent over the whole run, directed ones included
  localparam int RANDOM_ITEMS = 900;

  localparam sensor_word_t NO_WORD    = '0;
  localparam sensor_word_t SHORT_LINE = '{4'd0, 16'sd0, hsfp_pkg::ST_SHORT, 1'b1};
  localparam sensor_word_t BAD_WORD1  = '{4'd0, 16'sd0, hsfp_pkg::ST_BADHEX, 1'b0};

  // Directed characters
  localparam char_row_t DIRECTED [26] = '{
    '{8'hff,              1'b0, NO_WORD},     // all ones while seeking: ignored
    '{hsfp_pkg::CH_NL,    1'b0, NO_WORD},     // terminators before the colon: ignored
    '{hsfp_pkg::CH_NUL,   1'b0, NO_WORD},
    '{"x",                1'b0, NO_WORD},
    '{hsfp_pkg::CH_COLON, 1'b0, NO_WORD},
    '{hsfp_pkg::CH_NL,    1'b1, SHORT_LINE},  // line ends right after the colon
    '{hsfp_pkg::CH_COLON, 1'b0, NO_WORD},
    '{hsfp_pkg::CH_COLON, 1'b0, NO_WORD},     // skipped, even though it is a colon
    '{"1",                1'b0, NO_WORD},     // timestamp word, dropped
    '{"2",                1'b0, NO_WORD},
    '{"3",                1'b0, NO_WORD},
    '{"4",                1'b0, NO_WORD},
    '{hsfp_pkg::CH_SPACE, 1'b0, NO_WORD},     // space inside the digits
    '{"G",                1'b0, NO_WORD},     // uppercase is not a hex digit
    '{"0",                1'b0, NO_WORD},
    '{"0",                1'b0, NO_WORD},
    '{"0",                1'b1, BAD_WORD1},
    '{"f",                1'b0, NO_WORD},     // 0x7fff
    '{"f",                1'b0, NO_WORD},
    '{"7",                1'b0, NO_WORD},
    '{"f",                1'b0, NO_WORD},
    '{"0",                1'b0, NO_WORD},     // 0x8000
    '{"0",                1'b0, NO_WORD},
    '{"8",                1'b0, NO_WORD},
    '{"0",                1'b0, NO_WORD},
    '{hsfp_pkg::CH_NUL,   1'b1, SHORT_LINE}   // line ends during collection
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  hex_sensor_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Scoreboard state
  sensor_word_t due_words [$];
  char_row_t    sent_chars [$];
  int           mism_count = 0;
  int           work_items = 0;
  int           tx_calm = 0;
  int           rx_calm = 0;
  int           rx_hold = 0;
  bit           no_idle = 1'b0;

  // Parser model state
  parse_phase_t ph = SEEK_COLON;
  int unsigned  ndig = 0;
  logic [15:0]  acc = '0;
  logic         bad = 1'b0;

  task automatic log_mismatch(input string what, input sensor_word_t got,
                              input sensor_word_t want);
    $display({"%0t: %s: got ch=%0d smp=%0d st=%0d last=%0b,",
              " want ch=%0d smp=%0d st=%0d last=%0b"},
             $time, what, got.channel, got.sample, got.status, got.last,
             want.channel, want.sample, want.status, want.last);
    mism_count++;
  endtask

  // Advance the parser model by one character; returns 1 when a word comes out
  function automatic bit parse_char(input logic [7:0] c, output sensor_word_t w);
    logic        term;
    logic        hit;
    logic [3:0]  nib;
    int unsigned pos;
    int unsigned widx;
    term = (c == hsfp_pkg::CH_NL) || (c == hsfp_pkg::CH_NUL);
    hit = 1'b0;
    w = '0;
    case (ph)
      SEEK_COLON: begin
        if (c == hsfp_pkg::CH_COLON) begin
          ph = SKIP_ONE;
          ndig = 0;
          acc = '0;
          bad = 1'b0;
        end
      end
      SKIP_ONE: begin
        if (term) begin
          ph = SEEK_COLON;
          w = SHORT_LINE;
          hit = 1'b1;
        end else begin
          ph = COLLECT;
        end
      end
      COLLECT: begin
        if (term) begin
          ph = SEEK_COLON;
          w = SHORT_LINE;
          hit = 1'b1;
        end else if (c != hsfp_pkg::CH_SPACE) begin
          pos = ndig % 4;
          if (pos == 0) begin
            acc = '0;
            bad = 1'b0;
          end
          nib = '0;
          if (c >= 8'h30 && c <= 8'h39) nib = 4'(c - 8'h30);
          else if (c >= 8'h61 && c <= 8'h66) nib = 4'(c - 8'h57);
          else bad = 1'b1;
          // low byte first, high nibble of each byte first
          case (pos)
            0: acc[7:4] = nib;
            1: acc[3:0] = nib;
            2: acc[15:12] = nib;
            default: acc[11:8] = nib;
          endcase
          widx = ndig / 4;
          ndig++;
          if (pos == 3) begin
            if (widx + 1 >= NUM_WORDS) ph = LINE_DONE;
            if (widx != 0) begin
              w.channel = hsfp_pkg::CHAN_W'(widx - 1);
              w.sample  = bad ? 16'sd0 : acc;
              w.status  = bad ? hsfp_pkg::ST_BADHEX : hsfp_pkg::ST_OK;
              w.last    = (widx + 1 >= NUM_WORDS);
              hit = 1'b1;
            end
          end
        end
      end
      default: begin
        if (term) ph = SEEK_COLON;
      end
    endcase
    return hit;
  endfunction

  // Check results and predict on every accepted character
  always @(posedge clk) begin
    sensor_word_t got;
    sensor_word_t want;
    sensor_word_t pred;
    char_row_t    row;
    string        bad_fields;
    bit           made;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[3:0], m_tdata[19:4], m_tuser, m_tlast};
        if (due_words.size() == 0) begin
          log_mismatch("result with nothing expected", got, NO_WORD);
        end else begin
          want = due_words.pop_front();
          bad_fields = "";
          if (got.channel !== want.channel) bad_fields = {bad_fields, " channel"};
          if (got.sample !== want.sample) bad_fields = {bad_fields, " sample"};
          if (got.status !== want.status) bad_fields = {bad_fields, " status"};
          if (got.last !== want.last) bad_fields = {bad_fields, " last"};
          if (bad_fields != "") log_mismatch({"wrong", bad_fields}, got, want);
        end
      end
      if (s_tvalid && s_tready) begin
        row = sent_chars.pop_front();
        made = parse_char(s_tdata, pred);
        if (row.fixed) due_words.push_back(row.word);
        else if (made) due_words.push_back(pred);
      end
    end
  end

  // Receiver: ready with random stall bursts and calm stretches
  always @(posedge clk) begin
    if (rx_calm > 0) rx_calm <= rx_calm - 1;
    else if ($urandom_range(0, 99) == 0) rx_calm <= 80;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold  <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_calm == 0 && $urandom_range(0, 5) == 0) begin
      rx_hold  <= $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Send one character and wait until it is taken
  task automatic push_char(input char_row_t row);
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(0, 49) == 0) tx_calm = 60;
    if (!no_idle && tx_calm == 0 && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    sent_chars.push_back(row);
    work_items++;
    s_tvalid <= 1'b1;
    s_tdata  <= row.ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic feed(input logic [7:0] c);
    push_char('{c, 1'b0, NO_WORD});
  endtask

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    return (v < 10) ? 8'(8'h30 + v) : 8'(8'h57 + v);
  endfunction

  // Any character that is not hex, space or a terminator
  function automatic logic [7:0] junk_digit();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == hsfp_pkg::CH_SPACE || c == hsfp_pkg::CH_NL ||
               (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66));
    return c;
  endfunction

  function automatic logic [7:0] term_char();
    return $urandom_range(0, 1) ? hsfp_pkg::CH_NL : hsfp_pkg::CH_NUL;
  endfunction

  // One notification line: header, colon, skipped char, digits, terminator (or a terminator right after the colon)
  task automatic send_line();
    logic [7:0] c;
    int         cut;
    repeat ($urandom_range(0, 3)) begin
      c = 8'($urandom_range(0, 255));
      feed((c == hsfp_pkg::CH_COLON) ? 8'h78 : c);
    end
    feed(hsfp_pkg::CH_COLON);
    if ($urandom_range(0, 19) == 0) begin
      feed(term_char());
      return;
    end
    case ($urandom_range(0, 3))
      0: feed(hsfp_pkg::CH_SPACE);
      1: feed(hsfp_pkg::CH_COLON);
      2: feed(hex_char());
      default: feed(junk_digit());
    endcase
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, LINE_DIGITS - 1) : LINE_DIGITS;
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        feed(hsfp_pkg::CH_SPACE);
      end
      feed(($urandom_range(0, 29) == 0) ? junk_digit() : hex_char());
    end
    // trailing characters after a full line are ignored
    if (cut == LINE_DIGITS) begin
      repeat ($urandom_range(0, 3)) feed($urandom_range(0, 1) ? junk_digit() : hex_char());
    end
    feed(term_char());
  endtask

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) push_char(DIRECTED[i]);
    // hold off until every directed result is back
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    while (work_items < RANDOM_ITEMS) begin
      if (work_items > RANDOM_ITEMS - 120) no_idle = 1'b1;
      if ($urandom_range(0, 7) == 0) repeat (12) feed(8'($urandom_range(0, 255)));
      else send_line();
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mism_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
